### hw/rtl/sfid_pkg.sv
// Shared types, constants and codes for the lowest-free-id allocator.
// Used by sfid_ctrl, sfid_dp and smallest_free_id_allocator_unit; depends on nothing.
package sfid_pkg;

  localparam int unsigned MAX_IDS     = 255;
  localparam int unsigned STORE_DEPTH = 255;
  localparam int unsigned ID_CAP      = (MAX_IDS < STORE_DEPTH) ? MAX_IDS : STORE_DEPTH;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned SECTOR_SH   = 12;
  localparam int unsigned REC_ADDR_W  = 20;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] release_id;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0]       assigned_id;
    logic [REC_ADDR_W-1:0] record_address;
    logic [ID_W-1:0]       entry_count;
    logic [1:0]            status;
  } out_t;

  typedef struct packed {
    logic start;
    logic rd;
    logic step;
    logic tail;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
    logic err;
    logic sweep_done;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/sfid_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sfid_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### hw/rtl/sfid_dp.sv
// Datapath of the allocator: id list memory, sweep index, count and result register.
// Depends on sfid_pkg and sfid_ram.
module sfid_dp #(
  parameter int unsigned MaxIds = sfid_pkg::MAX_IDS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfid_pkg::dp_cmd_t cmd_i,
  output sfid_pkg::dp_stat_t stat_o,
  input  sfid_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sfid_pkg::out_t    out_data_o
);

  localparam int unsigned IdCap = (MaxIds < sfid_pkg::STORE_DEPTH) ? MaxIds :
                                  sfid_pkg::STORE_DEPTH;
  localparam logic [sfid_pkg::ID_W-1:0] IdCapV = sfid_pkg::ID_W'(IdCap);

  logic                        kind_q, kind_d;
  logic [sfid_pkg::ID_W-1:0]   rel_id_q, rel_id_d;
  logic [sfid_pkg::ID_W-1:0]   idx_q, idx_d;
  logic [sfid_pkg::ID_W-1:0]   pos_q, pos_d;
  logic [sfid_pkg::ID_W-1:0]   carry_q, carry_d;
  logic [sfid_pkg::ID_W-1:0]   cnt_q, cnt_d;
  logic                        found_q, found_d;
  logic [1:0]                  status_q, status_d;
  logic                        out_valid_q, out_valid_d;
  sfid_pkg::out_t              out_q, out_d;

  logic                        we;
  logic [sfid_pkg::ADDR_W-1:0] waddr;
  logic [sfid_pkg::ID_W-1:0]   wdata;
  logic [sfid_pkg::ID_W-1:0]   rdata;
  logic [sfid_pkg::ID_W-1:0]   idx_inc;
  logic [sfid_pkg::ID_W-1:0]   res_id;
  logic [1:0]                  res_status;

  sfid_ram #(
    .Width(sfid_pkg::ID_W),
    .Depth(sfid_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(idx_q[sfid_pkg::ADDR_W-1:0]),
    .rdata_o(rdata)
  );

  assign idx_inc = idx_q + 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q[sfid_pkg::ADDR_W-1:0];
    wdata = found_q ? carry_q : idx_inc;
    if (cmd_i.tail) begin
      we = 1'b1;
    end else if (cmd_i.step) begin
      if (kind_q == sfid_pkg::KIND_ALLOC) begin
        we = found_q || (rdata != idx_inc);
      end else if (found_q) begin
        we    = 1'b1;
        waddr = sfid_pkg::ADDR_W'(idx_q - 1'b1);
        wdata = rdata;
      end
    end
  end

  always_comb begin
    res_status = status_q;
    if (status_q == sfid_pkg::ST_OK && kind_q == sfid_pkg::KIND_RELEASE && !found_q) begin
      res_status = sfid_pkg::ST_NOT_FOUND;
    end
    if (res_status != sfid_pkg::ST_OK) begin
      res_id = '0;
    end else if (kind_q == sfid_pkg::KIND_ALLOC) begin
      res_id = pos_q + 1'b1;
    end else begin
      res_id = rel_id_q;
    end
  end

  always_comb begin
    kind_d      = kind_q;
    rel_id_d    = rel_id_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    carry_d     = carry_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.start) begin
      kind_d   = in_data_i.kind;
      rel_id_d = in_data_i.release_id;
      idx_d    = '0;
      found_d  = 1'b0;
      if (in_data_i.kind == sfid_pkg::KIND_ALLOC) begin
        status_d = (cnt_q >= IdCapV) ? sfid_pkg::ST_FULL : sfid_pkg::ST_OK;
      end else begin
        status_d = (cnt_q == '0) ? sfid_pkg::ST_EMPTY : sfid_pkg::ST_OK;
      end
    end
    if (cmd_i.step) begin
      idx_d = idx_inc;
      if (kind_q == sfid_pkg::KIND_ALLOC) begin
        if (found_q) begin
          carry_d = rdata;
        end else if (rdata != idx_inc) begin
          found_d = 1'b1;
          pos_d   = idx_q;
          carry_d = rdata;
        end
      end else if (!found_q && rdata == rel_id_q) begin
        found_d = 1'b1;
      end
    end
    if (cmd_i.tail && !found_q) begin
      pos_d = idx_q;
    end
    if (cmd_i.load) begin
      if (res_status == sfid_pkg::ST_OK) begin
        cnt_d = (kind_q == sfid_pkg::KIND_ALLOC) ? cnt_q + 1'b1 : cnt_q - 1'b1;
      end
      out_d.assigned_id    = res_id;
      out_d.record_address = {res_id, {sfid_pkg::SECTOR_SH{1'b0}}};
      out_d.entry_count    = cnt_d;
      out_d.status         = res_status;
      out_valid_d          = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= sfid_pkg::ST_OK;
      kind_q      <= sfid_pkg::KIND_ALLOC;
      idx_q       <= '0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      status_q    <= status_d;
      kind_q      <= kind_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_id_q <= rel_id_d;
    pos_q    <= pos_d;
    carry_q  <= carry_d;
    out_q    <= out_d;
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.err        = (status_q != sfid_pkg::ST_OK);
  assign stat_o.sweep_done = (idx_q == cnt_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_cnt_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdCapV)
    else $error("Entry count exceeds the list capacity.");

  a_sweep_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rd || cmd_i.step) |-> (idx_q < cnt_q))
    else $error("Sweep reads beyond the valid part of the list.");

  a_alloc_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && res_status == sfid_pkg::ST_OK && kind_q == sfid_pkg::KIND_ALLOC)
    |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("Successful allocate did not raise the entry count.");

  a_valid_rise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load))
    else $error("Result beat appeared without a result load.");
`endif

endmodule

### hw/rtl/sfid_ctrl.sv
// Sequencer of the allocator: accepts a request and steps the datapath sweep.
// Depends on sfid_pkg.
module sfid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfid_pkg::dp_stat_t stat_i,
  output sfid_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.err) begin
          state_d = S_RESULT;
        end else if (stat_i.sweep_done) begin
          state_d = (stat_i.kind == sfid_pkg::KIND_ALLOC) ? S_TAIL : S_RESULT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.step = 1'b1;
        state_d    = S_SCAN;
      end
      S_TAIL: begin
        cmd_o.tail = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

`ifndef NO_ASSERTIONS
  a_rd_then_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.step)
    else $error("Memory read was not followed by a sweep step.");

  a_start_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> in_stall_o)
    else $error("Input was not stalled while a request is in progress.");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("More than one datapath command in a cycle.");
`endif

endmodule

### hw/rtl/smallest_free_id_allocator_unit.sv
// Top level of the lowest-free-id allocator: sequencer plus datapath.
// Depends on sfid_pkg, sfid_ctrl and sfid_dp.
//
//   Channel  Direction  Handshake            Beat
//   in       input      in_valid_i/in_stall_o  kind, release_id
//   out      output     out_valid_o/out_stall_i assigned_id, record_address, entry_count, status
//
// A request sweeps the list memory one entry per read and check pair over the N ids in use,
// and an allocate adds a tail write; full or empty errors skip the sweep.
// Reset clears the count and the sequencer; the list memory itself needs no clearing.
// A waiting result beat does not block the next request, which stalls only at its end.
module smallest_free_id_allocator_unit #(
  parameter int unsigned MaxIds = sfid_pkg::MAX_IDS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sfid_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sfid_pkg::out_t out_data_o
);

  sfid_pkg::dp_cmd_t  cmd;
  sfid_pkg::dp_stat_t stat;

  sfid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sfid_dp #(
    .MaxIds(MaxIds)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### sim/smallest_free_id_allocator_unit_tb.sv
// Self-checking testbench for smallest_free_id_allocator_unit: directed and random allocate and
// release beats, with each result checked against a behavioural copy of the id list.
// Depends on sfid_pkg and the RTL of smallest_free_id_allocator_unit only.
`timescale 1ns / 1ps

class free_id_tracker;
  logic [sfid_pkg::ID_W-1:0] ids_in_use[$];
  sfid_pkg::out_t            pending_beats[$];
  int unsigned               errors;

  function new();
    errors = 0;
  endfunction

  function void note_request(sfid_pkg::in_t req);
    sfid_pkg::out_t res;
    int unsigned    pos;
    int unsigned    k;
    bit             hit;
    res = '0;
    if (req.kind == sfid_pkg::KIND_ALLOC) begin
      if (ids_in_use.size() >= sfid_pkg::ID_CAP) begin
        res.status = sfid_pkg::ST_FULL;
      end else begin
        pos = ids_in_use.size();
        hit = 1'b0;
        k = 0;
        while (!hit && k < ids_in_use.size()) begin
          if (ids_in_use[k] != sfid_pkg::ID_W'(k + 1)) begin
            pos = k;
            hit = 1'b1;
          end
          k++;
        end
        ids_in_use.insert(pos, sfid_pkg::ID_W'(pos + 1));
        res.assigned_id = sfid_pkg::ID_W'(pos + 1);
        res.status      = sfid_pkg::ST_OK;
      end
    end else begin
      if (ids_in_use.size() == 0) begin
        res.status = sfid_pkg::ST_EMPTY;
      end else begin
        hit = 1'b0;
        pos = 0;
        k = 0;
        while (!hit && k < ids_in_use.size()) begin
          if (ids_in_use[k] == req.release_id) begin
            pos = k;
            hit = 1'b1;
          end
          k++;
        end
        if (!hit) begin
          res.status = sfid_pkg::ST_NOT_FOUND;
        end else begin
          ids_in_use.delete(pos);
          res.assigned_id = req.release_id;
          res.status      = sfid_pkg::ST_OK;
        end
      end
    end
    res.record_address = sfid_pkg::REC_ADDR_W'(res.assigned_id) << sfid_pkg::SECTOR_SH;
    res.entry_count    = sfid_pkg::ID_W'(ids_in_use.size());
    pending_beats.push_back(res);
  endfunction

  function void check_beat(sfid_pkg::out_t got);
    sfid_pkg::out_t want;
    if (pending_beats.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %h", $time, got);
      errors++;
    end else begin
      want = pending_beats.pop_front();
      if (got.assigned_id !== want.assigned_id) begin
        $display("%0t: assigned_id expected %0d actual %0d", $time, want.assigned_id,
                 got.assigned_id);
        errors++;
      end
      if (got.record_address !== want.record_address) begin
        $display("%0t: record_address expected %h actual %h", $time, want.record_address,
                 got.record_address);
        errors++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                 got.entry_count);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
    end
  endfunction
endclass

module smallest_free_id_allocator_unit_tb;

  logic           clk_i      = 1'b0;
  logic           rst_ni     = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_stall;
  sfid_pkg::in_t  in_data    = '0;
  logic           out_valid;
  logic           out_stall  = 1'b0;
  sfid_pkg::out_t out_data;

  bit             quiet = 1'b0;
  free_id_tracker tracker;

  smallest_free_id_allocator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_req(input logic kind, input logic [sfid_pkg::ID_W-1:0] id);
    sfid_pkg::in_t req;
    req.kind       = kind;
    req.release_id = id;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    tracker.note_request(req);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int unsigned alloc_pct);
    logic [sfid_pkg::ID_W-1:0] id;
    if ($urandom_range(0, 99) < alloc_pct) begin
      send_req(sfid_pkg::KIND_ALLOC, '0);
    end else begin
      if (tracker.ids_in_use.size() != 0 && $urandom_range(0, 9) < 8) begin
        id = tracker.ids_in_use[$urandom_range(0, tracker.ids_in_use.size() - 1)];
      end else begin
        id = sfid_pkg::ID_W'($urandom_range(0, 255));
      end
      send_req(sfid_pkg::KIND_RELEASE, id);
    end
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && !out_stall) begin
        tracker.check_beat(out_data);
      end
      if (!quiet && stall_left == 0 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (quiet) begin
        stall_left = 0;
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) begin
        stall_left--;
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    tracker = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Releases on an empty list, dense appends, absent ids, and refilling of gaps.
    send_req(sfid_pkg::KIND_RELEASE, 8'd5);
    send_req(sfid_pkg::KIND_RELEASE, 8'd0);
    repeat (4) send_req(sfid_pkg::KIND_ALLOC, '0);
    send_req(sfid_pkg::KIND_RELEASE, 8'd0);
    send_req(sfid_pkg::KIND_RELEASE, 8'd255);
    send_req(sfid_pkg::KIND_RELEASE, 8'd2);
    send_req(sfid_pkg::KIND_RELEASE, 8'd2);
    send_req(sfid_pkg::KIND_ALLOC, '0);
    send_req(sfid_pkg::KIND_RELEASE, 8'd1);
    send_req(sfid_pkg::KIND_ALLOC, '0);
    send_req(sfid_pkg::KIND_RELEASE, 8'd4);
    send_req(sfid_pkg::KIND_RELEASE, 8'd3);
    send_req(sfid_pkg::KIND_RELEASE, 8'd2);
    send_req(sfid_pkg::KIND_RELEASE, 8'd1);
    send_req(sfid_pkg::KIND_RELEASE, 8'd1);
    send_req(sfid_pkg::KIND_ALLOC, '0);

    // Fill past capacity, drain much of the list, then a balanced mix.
    for (int i = 0; i < 800; i++) begin
      if (i >= 700) begin
        quiet = 1'b1;
      end
      if (i < 320) begin
        send_random(95);
      end else if (i < 560) begin
        send_random(15);
      end else begin
        send_random(50);
      end
    end
    in_valid <= 1'b0;

    while (tracker.pending_beats.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
